// ===== rtl/cht_pkg.sv =====
`default_nettype none
package cht_pkg;

    localparam int unsigned KEY_BITS = 31;
    localparam int unsigned CMD_BITS = 2;
    localparam int unsigned STATUS_BITS = 2;
    localparam int unsigned PAYLOAD_BITS = 64;

    typedef logic [CMD_BITS-1:0] t_cmd;
    typedef logic [STATUS_BITS-1:0] t_status;
    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [PAYLOAD_BITS-1:0] t_payload;

    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_SEARCH = 2'd1;
    localparam t_cmd CMD_DELETE = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_READ,
        S_CHECK,
        S_ALLOC,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/cht_if.sv =====
`default_nettype none
interface cht_req_if;
    logic              valid;
    logic              ready;
    cht_pkg::t_cmd     command;
    cht_pkg::t_key     lookup_key;
    cht_pkg::t_payload entry_value;
    modport source (output valid, command, lookup_key, entry_value, input ready);
    modport sink (input valid, command, lookup_key, entry_value, output ready);
endinterface

interface cht_rsp_if;
    logic              valid;
    logic              ready;
    cht_pkg::t_status  status;
    cht_pkg::t_payload found_value;
    modport source (output valid, status, found_value, input ready);
    modport sink (input valid, status, found_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/chained_hash_table_unit.sv =====
`default_nettype none
// Chained hash table: key/value store with separate chaining over a node pool.
// Request channel (i_req): command (insert/search/delete), key and value.
// Response channel (o_rsp): status and found value, one per request.
// Buckets are key mod BUCKETS; insert links the lowest free node at the head,
// search returns the first (newest) match, delete unlinks the first match.
// One request is processed at a time. The node memory has one registered
// read port, so each visited node takes an S_READ and an S_CHECK state.
// The bucket is found in S_HEAD: reciprocal multiply for the quotient, subtract
// for the remainder, then the bucket head is picked up.
// After a response the FSM goes through S_OUT back to S_IDLE before the
// next request can be taken.
// Reset clears the bucket heads (valid bits) and the in-use bitmap; no sweep.
// When the receiver stalls, the response register holds and no new request is
// taken until the response has been accepted.
module chained_hash_table_unit #(
    parameter int unsigned BUCKETS    = 13,
    parameter int unsigned NODES      = 64,
    parameter int unsigned VALUE_BITS = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cht_req_if.sink   i_req,
    cht_rsp_if.source o_rsp
);
    import cht_pkg::*;

    localparam int unsigned LW = $clog2(NODES + 1);
    localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned CW = 2;
    localparam logic [LW-1:0] NULL_LINK = LW'(NODES);
    // q = (key * RECIP) >> SH is exact for every 31-bit key
    localparam int unsigned SH = KEY_BITS + $clog2(BUCKETS);
    localparam logic [KEY_BITS:0] RECIP =
        (KEY_BITS+1)'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    // Node memory: key, value, next link
    logic [KEY_BITS-1:0]   mem_key  [NODES];
    logic [VALUE_BITS-1:0] mem_val  [NODES];
    logic [LW-1:0]         mem_next [NODES];

    // Bucket heads with valid bits (invalid reads as null)
    logic [LW-1:0]      r_head [BUCKETS];
    logic [BUCKETS-1:0] r_head_vld;
    logic [NODES-1:0]   r_in_use;

    t_state            r_state, n_state;
    t_cmd              r_cmd;
    t_key              r_key;
    t_key              r_quo;
    logic [VALUE_BITS-1:0] r_val;
    logic [BW-1:0]     r_rem;
    logic [CW-1:0]     r_cnt;
    logic [LW-1:0]     r_cur, r_prev;
    logic [LW:0]       r_steps;
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val;
    logic [LW-1:0]     r_rd_next;
    logic              r_rsp_vld;
    t_status           r_status;
    t_payload          r_found;

    logic [BW-1:0] bucket;
    assign bucket = r_rem;

    // Lowest free node (priority pick)
    logic [NW-1:0] free_idx;
    logic          free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                free_idx = NW'(i);
                free_any = 1'b1;
            end
        end
    end

    logic [LW-1:0] head_rd;
    assign head_rd = r_head_vld[bucket] ? r_head[bucket] : NULL_LINK;

    // Key modulo BUCKETS: quotient by reciprocal, then remainder
    logic [2*KEY_BITS:0] quo_prod;
    assign quo_prod = r_key * RECIP;

    logic [KEY_BITS-1:0] rem_full;
    assign rem_full = r_key - KEY_BITS'(r_quo * KEY_BITS'(BUCKETS));

    logic hit;
    assign hit = (r_rd_key == r_key);

    assign i_req.ready = (r_state == S_IDLE) && !r_rsp_vld;
    assign o_rsp.valid = r_rsp_vld;
    assign o_rsp.status = r_status;
    assign o_rsp.found_value = r_found;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_req.valid && i_req.ready) n_state = S_HEAD;
            S_HEAD:  if (r_cnt == CW'(2))
                         n_state = (r_cmd == CMD_INSERT) ? S_ALLOC :
                                   (r_cmd == CMD_SEARCH || r_cmd == CMD_DELETE)
                                   ? S_READ : S_OUT;
            S_READ:  n_state = S_CHECK;
            S_CHECK: n_state = S_READ;
            S_ALLOC: n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_READ && (r_cur >= NULL_LINK || r_steps >= (LW+1)'(NODES)))
            n_state = S_OUT;
        if (r_state == S_CHECK && hit) n_state = S_OUT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Memory read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ && r_cur < NULL_LINK) begin
            r_rd_key  <= mem_key[r_cur[NW-1:0]];
            r_rd_val  <= mem_val[r_cur[NW-1:0]];
            r_rd_next <= mem_next[r_cur[NW-1:0]];
        end
    end

    // Memory write port: insert fills a node, delete relinks predecessor
    always_ff @(posedge i_clk) begin
        if (r_state == S_ALLOC && free_any) begin
            mem_key[free_idx]  <= r_key;
            mem_val[free_idx]  <= r_val;
            mem_next[free_idx] <= head_rd;
        end else if (r_state == S_CHECK && hit && r_cmd == CMD_DELETE
                     && r_prev < NULL_LINK) begin
            mem_next[r_prev[NW-1:0]] <= r_rd_next;
        end
    end

    // Datapath and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= '0;
            r_in_use   <= '0;
            r_rsp_vld  <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) r_rsp_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_cmd    <= i_req.command;
                        r_key    <= i_req.lookup_key;
                        r_val    <= i_req.entry_value[VALUE_BITS-1:0];
                        r_rem    <= '0;
                        r_cnt    <= '0;
                        r_status <= ST_OK;
                        r_found  <= '0;
                    end
                end
                S_HEAD: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(0)) begin
                        r_quo <= KEY_BITS'(quo_prod >> SH);
                    end else if (r_cnt == CW'(1)) begin
                        r_rem <= rem_full[BW-1:0];
                    end else begin
                        // bucket known: start the walk at its head
                        r_cur   <= head_rd;
                        r_prev  <= NULL_LINK;
                        r_steps <= '0;
                    end
                end
                S_READ: begin
                    if (r_cur >= NULL_LINK || r_steps >= (LW+1)'(NODES)) begin
                        r_status  <= ST_NOT_FOUND;
                        r_rsp_vld <= 1'b1;
                    end
                end
                S_CHECK: begin
                    if (hit) begin
                        if (r_cmd == CMD_SEARCH) begin
                            r_found <= t_payload'(r_rd_val);
                        end else begin
                            if (r_prev >= NULL_LINK) begin
                                r_head[bucket]     <= r_rd_next;
                                r_head_vld[bucket] <= 1'b1;
                            end
                            r_in_use[r_cur[NW-1:0]] <= 1'b0;
                        end
                        r_rsp_vld <= 1'b1;
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= r_rd_next;
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_ALLOC: begin
                    if (free_any) begin
                        r_in_use[free_idx] <= 1'b1;
                        r_head[bucket]     <= LW'(free_idx);
                        r_head_vld[bucket] <= 1'b1;
                    end else begin
                        r_status <= ST_FULL;
                    end
                    r_rsp_vld <= 1'b1;
                end
                S_OUT: begin
                    if (r_cmd != CMD_INSERT && r_cmd != CMD_SEARCH && r_cmd != CMD_DELETE)
                        r_rsp_vld <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire
